@@ hw/rtl/svu_pkg.sv @@
package svu_pkg;

  localparam int unsigned MaxRefWidth  = 256;
  localparam int unsigned MaxRefHeight = 256;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned SampleW      = 12;
  localparam int unsigned PosW         = 13;
  localparam int unsigned PartW        = 21;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_LUMA   = 2'd1,
    OP_CHROMA = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_REF_WIDTH     = 3'd0,
    CFG_REF_HEIGHT    = 3'd1,
    CFG_REF_BIT_DEPTH = 3'd2,
    CFG_OUT_BIT_DEPTH = 3'd3,
    CFG_POS_OFFSET    = 3'd4,
    CFG_POS_DELTA     = 3'd5,
    CFG_POS_SCALE     = 3'd6,
    CFG_POS_ROUND_ADD = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_ROW,
    ST_ROW_END,
    ST_COL,
    ST_FINISH,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       take;      // latch the accepted item
    logic       do_load;   // write store
    logic       map_x;     // position mapping, x half
    logic       map_y;     // position mapping, y half
    logic       row_clr;   // clear row accumulator
    logic       row_mac;   // read data valid, accumulate
    logic       row_read;  // issue store read
    logic       row_save;  // save row partial
    logic       col_mac;   // vertical accumulate
    logic       col_clr;
    logic       finish;    // round, shift, clip into output register
    logic       out_take;  // output item delivered
    logic [2:0] k;         // horizontal tap index for read
    logic [2:0] k_mac;     // horizontal tap index of returning data
    logic [2:0] n;         // row index
  } svu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic luma;
    logic out_valid;
  } svu_sts_t;

  function automatic logic signed [7:0] luma_tap(input logic [3:0] ph,
                                                 input logic [2:0] k);
    logic signed [7:0] r [8];
    unique case (ph)
      4'd0:  r = '{8'sd0, 8'sd0, 8'sd0, 8'sd64, 8'sd0, 8'sd0, 8'sd0, 8'sd0};
      4'd1:  r = '{8'sd0, 8'sd1, -8'sd3, 8'sd63, 8'sd4, -8'sd2, 8'sd1, 8'sd0};
      4'd2:  r = '{-8'sd1, 8'sd2, -8'sd5, 8'sd62, 8'sd8, -8'sd3, 8'sd1, 8'sd0};
      4'd3:  r = '{-8'sd1, 8'sd3, -8'sd8, 8'sd60, 8'sd13, -8'sd4, 8'sd1, 8'sd0};
      4'd4:  r = '{-8'sd1, 8'sd4, -8'sd10, 8'sd58, 8'sd17, -8'sd5, 8'sd1, 8'sd0};
      4'd5:  r = '{-8'sd1, 8'sd4, -8'sd11, 8'sd52, 8'sd26, -8'sd8, 8'sd3, -8'sd1};
      4'd6:  r = '{-8'sd1, 8'sd3, -8'sd9, 8'sd47, 8'sd31, -8'sd10, 8'sd4, -8'sd1};
      4'd7:  r = '{-8'sd1, 8'sd4, -8'sd11, 8'sd45, 8'sd34, -8'sd10, 8'sd4, -8'sd1};
      4'd8:  r = '{-8'sd1, 8'sd4, -8'sd11, 8'sd40, 8'sd40, -8'sd11, 8'sd4, -8'sd1};
      4'd9:  r = '{-8'sd1, 8'sd4, -8'sd10, 8'sd34, 8'sd45, -8'sd11, 8'sd4, -8'sd1};
      4'd10: r = '{-8'sd1, 8'sd4, -8'sd10, 8'sd31, 8'sd47, -8'sd9, 8'sd3, -8'sd1};
      4'd11: r = '{-8'sd1, 8'sd3, -8'sd8, 8'sd26, 8'sd52, -8'sd11, 8'sd4, -8'sd1};
      4'd12: r = '{8'sd0, 8'sd1, -8'sd5, 8'sd17, 8'sd58, -8'sd10, 8'sd4, -8'sd1};
      4'd13: r = '{8'sd0, 8'sd1, -8'sd4, 8'sd13, 8'sd60, -8'sd8, 8'sd3, -8'sd1};
      4'd14: r = '{8'sd0, 8'sd1, -8'sd3, 8'sd8, 8'sd62, -8'sd5, 8'sd2, -8'sd1};
      default: r = '{8'sd0, 8'sd1, -8'sd2, 8'sd4, 8'sd63, -8'sd3, 8'sd1, 8'sd0};
    endcase
    return r[k];
  endfunction

  function automatic logic signed [7:0] chroma_tap(input logic [3:0] ph,
                                                   input logic [1:0] k);
    logic signed [7:0] r [4];
    unique case (ph)
      4'd0:  r = '{8'sd0, 8'sd64, 8'sd0, 8'sd0};
      4'd1:  r = '{-8'sd2, 8'sd62, 8'sd4, 8'sd0};
      4'd2:  r = '{-8'sd2, 8'sd58, 8'sd10, -8'sd2};
      4'd3:  r = '{-8'sd4, 8'sd56, 8'sd14, -8'sd2};
      4'd4:  r = '{-8'sd4, 8'sd54, 8'sd16, -8'sd2};
      4'd5:  r = '{-8'sd6, 8'sd52, 8'sd20, -8'sd2};
      4'd6:  r = '{-8'sd6, 8'sd46, 8'sd28, -8'sd4};
      4'd7:  r = '{-8'sd4, 8'sd42, 8'sd30, -8'sd4};
      4'd8:  r = '{-8'sd4, 8'sd36, 8'sd36, -8'sd4};
      4'd9:  r = '{-8'sd4, 8'sd30, 8'sd42, -8'sd4};
      4'd10: r = '{-8'sd4, 8'sd28, 8'sd46, -8'sd6};
      4'd11: r = '{-8'sd2, 8'sd20, 8'sd52, -8'sd6};
      4'd12: r = '{-8'sd2, 8'sd16, 8'sd54, -8'sd4};
      4'd13: r = '{-8'sd2, 8'sd14, 8'sd56, -8'sd4};
      4'd14: r = '{-8'sd2, 8'sd10, 8'sd58, -8'sd2};
      default: r = '{8'sd0, 8'sd4, 8'sd62, -8'sd2};
    endcase
    return r[k];
  endfunction

endpackage

@@ hw/rtl/svu_item_if.sv @@
interface svu_item_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic [svu_pkg::PosW-1:0]       pos_x;
  logic [svu_pkg::PosW-1:0]       pos_y;
  logic [svu_pkg::SampleW-1:0]    sample_in;
  modport source (output valid, op, pos_x, pos_y, sample_in, input ready);
  modport sink (input valid, op, pos_x, pos_y, sample_in, output ready);
endinterface

@@ hw/rtl/svu_result_if.sv @@
interface svu_result_if;
  logic                        valid;
  logic                        ready;
  logic [svu_pkg::SampleW-1:0] out_sample;
  modport source (output valid, out_sample, input ready);
  modport sink (input valid, out_sample, output ready);
endinterface

@@ hw/rtl/svu_cfg_if.sv @@
interface svu_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [svu_pkg::CfgIdxW-1:0]  index;
  logic [svu_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/scalable_video_upsampler.sv @@
// Inter-layer upsampler.
// in_*: load items (op 0) write one 12-bit sample into the picture store;
//   request items (op 1 luma, op 2 chroma) name one output coordinate.
// out_*: one 12-bit resampled sample per request, none for a load or op 3.
// cfg_*: register writes (index 0..7), taken at any time, meant while idle.
// A load is written when it is accepted. A request maps its position (x half,
//   then y half), then reads the tap window from the single-port store one
//   sample per cycle: luma is 8 rows of 8 reads, chroma 4 rows of 4, each row
//   closed by saving its partial; then the vertical taps are accumulated and
//   the result is finished into the output register, and the next item is
//   taken after the output state.
// The store read port sets the rate; one item is in work at a time.
// The result sits in an output register; a stalled receiver holds it, and
//   the next request finishes only after it is taken.
// Reset (rst_n low, synchronous) restores register defaults, clears the
//   output and control state; the store is not cleared and reads of unloaded
//   entries are undefined.
module scalable_video_upsampler #(
  parameter int unsigned MAX_REF_WIDTH  = svu_pkg::MaxRefWidth,
  parameter int unsigned MAX_REF_HEIGHT = svu_pkg::MaxRefHeight
) (
  input  logic clk,
  input  logic rst_n,
  svu_item_if.sink     in_if,
  svu_result_if.source out_if,
  svu_cfg_if.sink      cfg_if
);

  svu_pkg::svu_cmd_t cmd;
  svu_pkg::svu_sts_t sts;

  assign cfg_if.ready = 1'b1;

  svu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_op     (in_if.op),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  svu_datapath #(
    .MAX_REF_WIDTH  (MAX_REF_WIDTH),
    .MAX_REF_HEIGHT (MAX_REF_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_op        (in_if.op),
    .in_pos_x     (in_if.pos_x),
    .in_pos_y     (in_if.pos_y),
    .in_sample_in (in_if.sample_in),
    .cfg_we       (cfg_if.valid),
    .cfg_index    (cfg_if.index),
    .cfg_data     (cfg_if.data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_if.valid),
    .out_sample   (out_if.out_sample)
  );

`ifndef ASSERT_OFF
  // output register never loaded while a stalled result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |-> !cmd.finish)
    else $error("result overwritten");
  // result only after a finish command
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(cmd.finish))
    else $error("result without finish");
  // no input accepted while a request is in work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.row_read || cmd.col_mac) |-> !in_if.ready)
    else $error("accept while busy");
`endif

endmodule

@@ hw/rtl/svu_ctrl.sv @@
module svu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  input  logic              out_ready,
  input  svu_pkg::svu_sts_t sts,
  output svu_pkg::svu_cmd_t cmd
);

  svu_pkg::state_t state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic [2:0] n_r, n_nxt;
  logic       rd_v_r, rd_v_nxt;
  logic [2:0] rd_k_r, rd_k_nxt;
  logic [2:0] last;

  assign last = sts.luma ? 3'd7 : 3'd3;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svu_pkg::ST_IDLE;
      k_r     <= '0;
      n_r     <= '0;
      rd_v_r  <= 1'b0;
      rd_k_r  <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      rd_v_r  <= rd_v_nxt;
      rd_k_r  <= rd_k_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    rd_v_nxt  = 1'b0;
    rd_k_nxt  = k_r;
    cmd       = '0;
    cmd.k     = k_r;
    cmd.k_mac = rd_k_r;
    cmd.n     = n_r;
    cmd.row_mac = rd_v_r;
    in_ready  = 1'b0;
    cmd.out_take = sts.out_valid && out_ready;
    unique case (state_r)
      svu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          priority if (in_op == svu_pkg::OP_LOAD) cmd.do_load = 1'b1;
          else if (in_op == svu_pkg::OP_NONE) state_nxt = svu_pkg::ST_IDLE;
          else state_nxt = svu_pkg::ST_MAP_X;
        end
      end
      svu_pkg::ST_MAP_X: begin
        cmd.map_x = 1'b1;
        state_nxt = svu_pkg::ST_MAP_Y;
      end
      svu_pkg::ST_MAP_Y: begin
        cmd.map_y   = 1'b1;
        cmd.row_clr = 1'b1;
        k_nxt = '0;
        n_nxt = '0;
        state_nxt = svu_pkg::ST_ROW;
      end
      svu_pkg::ST_ROW: begin
        cmd.row_read = 1'b1;
        rd_v_nxt = 1'b1;
        rd_k_nxt = k_r;
        if (k_r == last) begin
          k_nxt = '0;
          state_nxt = svu_pkg::ST_ROW_END;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      svu_pkg::ST_ROW_END: begin
        // last product lands in this cycle, then save
        if (!rd_v_r) begin
          cmd.row_save = 1'b1;
          cmd.row_clr  = 1'b1;
          if (n_r == last) begin
            n_nxt = '0;
            cmd.col_clr = 1'b1;
            state_nxt = svu_pkg::ST_COL;
          end else begin
            n_nxt = n_r + 3'd1;
            state_nxt = svu_pkg::ST_ROW;
          end
        end
      end
      svu_pkg::ST_COL: begin
        cmd.col_mac = 1'b1;
        if (n_r == last) begin
          n_nxt = '0;
          state_nxt = svu_pkg::ST_FINISH;
        end else begin
          n_nxt = n_r + 3'd1;
        end
      end
      svu_pkg::ST_FINISH: begin
        if (!sts.out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt = svu_pkg::ST_OUT;
        end
      end
      svu_pkg::ST_OUT: begin
        state_nxt = svu_pkg::ST_IDLE;
      end
      default: state_nxt = svu_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/svu_datapath.sv @@
module svu_datapath #(
  parameter int unsigned MAX_REF_WIDTH  = svu_pkg::MaxRefWidth,
  parameter int unsigned MAX_REF_HEIGHT = svu_pkg::MaxRefHeight
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_op,
  input  logic [svu_pkg::PosW-1:0]      in_pos_x,
  input  logic [svu_pkg::PosW-1:0]      in_pos_y,
  input  logic [svu_pkg::SampleW-1:0]   in_sample_in,
  input  logic                          cfg_we,
  input  logic [svu_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [svu_pkg::CfgDataW-1:0]  cfg_data,
  input  svu_pkg::svu_cmd_t             cmd,
  output svu_pkg::svu_sts_t             sts,
  output logic                          out_valid,
  output logic [svu_pkg::SampleW-1:0]   out_sample
);

  localparam int unsigned XW    = $clog2(MAX_REF_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_REF_HEIGHT);
  localparam int unsigned Depth = (1 << XW) * MAX_REF_HEIGHT;
  localparam int unsigned SzW   = 14;

  // configuration registers
  logic [8:0]  ref_width_r, ref_height_r;
  logic [3:0]  ref_bd_r, out_bd_r;
  logic [63:0] offset_r, delta_r, scale_r, radd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_width_r  <= 9'd256;
      ref_height_r <= 9'd256;
      ref_bd_r     <= 4'd8;
      out_bd_r     <= 4'd8;
      offset_r     <= '0;
      delta_r      <= '0;
      scale_r      <= 64'h0001_0000_0001_0000;
      radd_r       <= '0;
    end else if (cfg_we) begin
      unique case (svu_pkg::cfg_idx_t'(cfg_index))
        svu_pkg::CFG_REF_WIDTH:     ref_width_r  <= cfg_data[8:0];
        svu_pkg::CFG_REF_HEIGHT:    ref_height_r <= cfg_data[8:0];
        svu_pkg::CFG_REF_BIT_DEPTH: ref_bd_r     <= cfg_data[3:0];
        svu_pkg::CFG_OUT_BIT_DEPTH: out_bd_r     <= cfg_data[3:0];
        svu_pkg::CFG_POS_OFFSET:    offset_r     <= cfg_data;
        svu_pkg::CFG_POS_DELTA:     delta_r      <= cfg_data;
        svu_pkg::CFG_POS_SCALE:     scale_r      <= cfg_data;
        default:                    radd_r       <= cfg_data;
      endcase
    end
  end

  // effective sizes and shifts
  logic [SzW-1:0] w_eff, h_eff;
  logic [3:0]     rbd, obd;
  logic [2:0]     shift1;
  logic [3:0]     shift2;
  always_comb begin
    w_eff = (ref_width_r == 9'd0) ? SzW'(1) : SzW'(ref_width_r);
    if (w_eff > SzW'(MAX_REF_WIDTH)) w_eff = SzW'(MAX_REF_WIDTH);
    h_eff = (ref_height_r == 9'd0) ? SzW'(1) : SzW'(ref_height_r);
    if (h_eff > SzW'(MAX_REF_HEIGHT)) h_eff = SzW'(MAX_REF_HEIGHT);
    rbd = (ref_bd_r < 4'd8) ? 4'd8 : ((ref_bd_r > 4'd12) ? 4'd12 : ref_bd_r);
    obd = (out_bd_r < 4'd8) ? 4'd8 : ((out_bd_r > 4'd12) ? 4'd12 : out_bd_r);
    shift1 = 3'(rbd - 4'd8);
    shift2 = 4'(5'd20 - {1'b0, obd});
  end

  // item latch
  logic                    luma_r;
  logic [svu_pkg::PosW-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) luma_r <= 1'b0;
    else if (cmd.take) luma_r <= (in_op == svu_pkg::OP_LUMA);
  end
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
    end
  end

  // position mapping, one half per cycle, 34x33 signed multiply mod 2^64
  logic [svu_pkg::PosW-1:0] map_p;
  logic [31:0]              map_off, map_scl, map_add, map_dlt;
  logic signed [33:0]       map_d;
  logic signed [66:0]       map_m;
  logic [63:0]              map_u, map_r;
  always_comb begin
    if (cmd.map_y) begin
      map_p   = py_r;
      map_off = offset_r[63:32];
      map_scl = scale_r[63:32];
      map_add = radd_r[63:32];
      map_dlt = delta_r[63:32];
    end else begin
      map_p   = px_r;
      map_off = offset_r[31:0];
      map_scl = scale_r[31:0];
      map_add = radd_r[31:0];
      map_dlt = delta_r[31:0];
    end
    map_d = $signed(34'(map_p)) - $signed({{2{map_off[31]}}, map_off});
    map_m = map_d * $signed({1'b0, map_scl});
    map_u = map_m[63:0] + {{32{map_add[31]}}, map_add} + 64'd2048;
    map_r = 64'($signed(map_u) >>> 12) + {{32{map_dlt[31]}}, map_dlt};
  end

  logic signed [59:0] xr_r, yr_r;
  logic [3:0]         xph_r, yph_r;
  always_ff @(posedge clk) begin
    if (cmd.map_x) begin
      xr_r  <= map_r[63:4];
      xph_r <= map_r[3:0];
    end
    if (cmd.map_y) begin
      yr_r  <= map_r[63:4];
      yph_r <= map_r[3:0];
    end
  end

  // clamped coordinates of the current tap
  logic signed [60:0] xs, ys;
  logic [XW-1:0]      xx;
  logic [YW-1:0]      yy;
  always_comb begin
    xs = 61'(xr_r) + 61'(cmd.k) - (luma_r ? 61'sd3 : 61'sd1);
    ys = 61'(yr_r) + 61'(cmd.n) - (luma_r ? 61'sd3 : 61'sd1);
    if (xs < 0) xx = '0;
    else if (xs > 61'(w_eff) - 61'sd1) xx = XW'(w_eff - SzW'(1));
    else xx = xs[XW-1:0];
    if (ys < 0) yy = '0;
    else if (ys > 61'(h_eff) - 61'sd1) yy = YW'(h_eff - SzW'(1));
    else yy = ys[YW-1:0];
  end

  // picture store, single port
  logic [svu_pkg::SampleW-1:0] mem [Depth];
  logic [svu_pkg::SampleW-1:0] rd_q;
  logic                        ld_ok;
  assign ld_ok = (32'(in_pos_x) < MAX_REF_WIDTH) && (32'(in_pos_y) < MAX_REF_HEIGHT);
  always_ff @(posedge clk) begin
    if (cmd.do_load && ld_ok)
      mem[{in_pos_y[YW-1:0], in_pos_x[XW-1:0]}] <= in_sample_in;
    else if (cmd.row_read)
      rd_q <= mem[{yy, xx}];
  end

  // horizontal multiply accumulate
  logic signed [7:0]  hc;
  logic signed [24:0] hacc_r;
  always_comb begin
    hc = luma_r ? svu_pkg::luma_tap(xph_r, cmd.k_mac)
                : svu_pkg::chroma_tap(xph_r, cmd.k_mac[1:0]);
  end
  always_ff @(posedge clk) begin
    if (cmd.row_clr) hacc_r <= '0;
    else if (cmd.row_mac) hacc_r <= hacc_r + 25'(hc * $signed({1'b0, rd_q}));
  end

  // row partials
  logic signed [svu_pkg::PartW-1:0] part_r [8];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) part_r[i] <= '0;
    end else if (cmd.row_save) begin
      part_r[cmd.n] <= svu_pkg::PartW'(hacc_r >>> shift1);
    end
  end

  // vertical multiply accumulate
  logic signed [7:0]  vc;
  logic signed [31:0] vacc_r;
  always_comb begin
    vc = luma_r ? svu_pkg::luma_tap(yph_r, cmd.n)
                : svu_pkg::chroma_tap(yph_r, cmd.n[1:0]);
  end
  always_ff @(posedge clk) begin
    if (cmd.col_clr) vacc_r <= '0;
    else if (cmd.col_mac) vacc_r <= vacc_r + 32'(vc * part_r[cmd.n]);
  end

  // round, shift, clip, output register
  logic signed [31:0] rnd;
  logic [12:0]        maxv;
  logic [svu_pkg::SampleW-1:0] clip;
  always_comb begin
    rnd  = (vacc_r + (32'sd1 <<< (shift2 - 4'd1))) >>> shift2;
    maxv = 13'((14'd1 << obd) - 14'd1);
    if (rnd < 0) clip = '0;
    else if (rnd > 32'(maxv)) clip = maxv[11:0];
    else clip = rnd[11:0];
  end

  logic                        ov_r;
  logic [svu_pkg::SampleW-1:0] os_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.finish) ov_r <= 1'b1;
    else if (cmd.out_take) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.finish) os_r <= clip;
  end

  assign out_valid     = ov_r;
  assign out_sample    = os_r;
  assign sts.luma      = luma_r;
  assign sts.out_valid = ov_r;

endmodule

@@ tb/tb_scalable_video_upsampler.sv @@
module tb_scalable_video_upsampler;
  timeunit 1ns;
  timeprecision 1ps;

  import svu_pkg::*;

  localparam int StoreW = MaxRefWidth;
  localparam int StoreH = MaxRefHeight;
  // loaded corner of the store; requests read outside it only when the picture size exceeds it
  localparam int FillSide = 16;
  localparam logic [11:0] FillLevel = 12'h080;

  localparam int LumaCoef [16][8] = '{
    '{ 0, 0,   0, 64,  0,   0, 0,  0}, '{ 0, 1,  -3, 63,  4,  -2, 1,  0},
    '{-1, 2,  -5, 62,  8,  -3, 1,  0}, '{-1, 3,  -8, 60, 13,  -4, 1,  0},
    '{-1, 4, -10, 58, 17,  -5, 1,  0}, '{-1, 4, -11, 52, 26,  -8, 3, -1},
    '{-1, 3,  -9, 47, 31, -10, 4, -1}, '{-1, 4, -11, 45, 34, -10, 4, -1},
    '{-1, 4, -11, 40, 40, -11, 4, -1}, '{-1, 4, -10, 34, 45, -11, 4, -1},
    '{-1, 4, -10, 31, 47,  -9, 3, -1}, '{-1, 3,  -8, 26, 52, -11, 4, -1},
    '{ 0, 1,  -5, 17, 58, -10, 4, -1}, '{ 0, 1,  -4, 13, 60,  -8, 3, -1},
    '{ 0, 1,  -3,  8, 62,  -5, 2, -1}, '{ 0, 1,  -2,  4, 63,  -3, 1,  0}};

  localparam int ChromaCoef [16][4] = '{
    '{ 0, 64,  0,  0}, '{-2, 62,  4,  0}, '{-2, 58, 10, -2}, '{-4, 56, 14, -2},
    '{-4, 54, 16, -2}, '{-6, 52, 20, -2}, '{-6, 46, 28, -4}, '{-4, 42, 30, -4},
    '{-4, 36, 36, -4}, '{-4, 30, 42, -4}, '{-4, 28, 46, -6}, '{-2, 20, 52, -6},
    '{-2, 16, 54, -4}, '{-2, 14, 56, -4}, '{-2, 10, 58, -2}, '{ 0,  4, 62, -2}};

  typedef struct {
    op_t         op;
    logic [12:0] x;
    logic [12:0] y;
    logic [11:0] smp;
    bit          fixed;
    logic [11:0] want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  svu_item_if   in_if();
  svu_result_if out_if();
  svu_cfg_if    cfg_if();

  scalable_video_upsampler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // mirror of the block state
  logic [11:0] pic_mirror [StoreW*StoreH];
  logic [63:0] reg_mirror [8];
  logic [11:0] pending_samples [$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  stim_row_t directed_rows [22] = '{
    '{OP_LUMA,   13'd0,    13'd0,    12'd0,    1'b1, FillLevel},
    '{OP_LUMA,   13'd8191, 13'd8191, 12'd4095, 1'b1, FillLevel},
    '{OP_CHROMA, 13'd0,    13'd8191, 12'd0,    1'b1, FillLevel},
    '{OP_CHROMA, 13'd8191, 13'd0,    12'd0,    1'b1, FillLevel},
    '{OP_NONE,   13'd5,    13'd5,    12'd4095, 1'b0, 12'd0},
    '{OP_LOAD,   13'd8191, 13'd0,    12'd4095, 1'b0, 12'd0},
    '{OP_LOAD,   13'd0,    13'd8191, 12'd4095, 1'b0, 12'd0},
    '{OP_LOAD,   13'd256,  13'd255,  12'd4095, 1'b0, 12'd0},
    '{OP_LUMA,   13'd255,  13'd0,    12'd0,    1'b1, FillLevel},
    '{OP_LOAD,   13'd0,    13'd0,    12'd4095, 1'b0, 12'd0},
    '{OP_LOAD,   13'd255,  13'd255,  12'd0,    1'b0, 12'd0},
    '{OP_LOAD,   13'd1,    13'd0,    12'd4095, 1'b0, 12'd0},
    '{OP_LOAD,   13'd0,    13'd1,    12'd4095, 1'b0, 12'd0},
    '{OP_LUMA,   13'd0,    13'd0,    12'd0,    1'b0, 12'd0},
    '{OP_CHROMA, 13'd0,    13'd0,    12'd0,    1'b0, 12'd0},
    '{OP_LUMA,   13'd255,  13'd255,  12'd0,    1'b0, 12'd0},
    '{OP_CHROMA, 13'd254,  13'd255,  12'd0,    1'b0, 12'd0},
    '{OP_LUMA,   13'd1,    13'd1,    12'd0,    1'b0, 12'd0},
    '{OP_LOAD,   13'd8,    13'd8,    12'd2730, 1'b0, 12'd0},
    '{OP_LOAD,   13'd9,    13'd8,    12'd1365, 1'b0, 12'd0},
    '{OP_LUMA,   13'd8,    13'd8,    12'd0,    1'b0, 12'd0},
    '{OP_CHROMA, 13'd9,    13'd8,    12'd0,    1'b0, 12'd0}};

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // output position to 1/16-sample reference position, modulo 2^64
  function automatic logic [63:0] map_to_ref16(input logic [12:0] p, input logic [31:0] off,
                                               input logic [31:0] scl, input logic [31:0] add,
                                               input logic [31:0] dlt);
    logic [63:0] u;
    logic signed [63:0] s;
    u = {51'd0, p} - {{32{off[31]}}, off};
    u = u * {32'd0, scl};
    u = u + {{32{add[31]}}, add} + 64'd2048;
    s = $signed(u);
    s = s >>> 12;
    u = s;
    u = u + {{32{dlt[31]}}, dlt};
    return u;
  endfunction

  function automatic int clamp_coord(input longint p, input int size);
    if (p < 0) return 0;
    if (p > size - 1) return size - 1;
    return int'(p);
  endfunction

  function automatic int sat_range(input longint v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // separable resampling of one output sample
  function automatic logic [11:0] resample_predict(input op_t op, input logic [12:0] px,
                                                   input logic [12:0] py);
    bit luma;
    int ntap, back, w, h, sh1, obd, sh2, xph, yph, coef, xx, yy;
    logic [63:0] x16, y16;
    longint xr, yr, acc, maxv;
    longint partial [8];
    luma = (op == OP_LUMA);
    ntap = luma ? 8 : 4;
    back = luma ? 3 : 1;
    w    = sat_range(reg_mirror[CFG_REF_WIDTH], 1, StoreW);
    h    = sat_range(reg_mirror[CFG_REF_HEIGHT], 1, StoreH);
    sh1  = sat_range(reg_mirror[CFG_REF_BIT_DEPTH], 8, 12) - 8;
    obd  = sat_range(reg_mirror[CFG_OUT_BIT_DEPTH], 8, 12);
    sh2  = 20 - obd;
    x16 = map_to_ref16(px, reg_mirror[CFG_POS_OFFSET][31:0], reg_mirror[CFG_POS_SCALE][31:0],
                       reg_mirror[CFG_POS_ROUND_ADD][31:0], reg_mirror[CFG_POS_DELTA][31:0]);
    y16 = map_to_ref16(py, reg_mirror[CFG_POS_OFFSET][63:32],
                       reg_mirror[CFG_POS_SCALE][63:32],
                       reg_mirror[CFG_POS_ROUND_ADD][63:32], reg_mirror[CFG_POS_DELTA][63:32]);
    xr = x16;
    xr = xr >>> 4;
    yr = y16;
    yr = yr >>> 4;
    xph = x16[3:0];
    yph = y16[3:0];
    // horizontal pass, one partial per row
    for (int n = 0; n < ntap; n++) begin
      yy = clamp_coord(yr + n - back, h);
      acc = 0;
      for (int k = 0; k < ntap; k++) begin
        xx = clamp_coord(xr + k - back, w);
        coef = luma ? LumaCoef[xph][k] : ChromaCoef[xph][k];
        acc += longint'(coef) * longint'(pic_mirror[yy*StoreW + xx]);
      end
      partial[n] = acc >>> sh1;
    end
    // vertical pass, round and clip
    acc = 0;
    for (int n = 0; n < ntap; n++) begin
      coef = luma ? LumaCoef[yph][n] : ChromaCoef[yph][n];
      acc += longint'(coef) * partial[n];
    end
    acc = (acc + (longint'(1) << (sh2 - 1))) >>> sh2;
    maxv = (longint'(1) << obd) - 1;
    if (acc < 0) acc = 0;
    if (acc > maxv) acc = maxv;
    return acc[11:0];
  endfunction

  // drive one item, return after the accepting edge
  task automatic send_item(input op_t op, input logic [12:0] px, input logic [12:0] py,
                           input logic [11:0] smp, input bit fixed, input logic [11:0] want);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.pos_x     <= px;
    in_if.pos_y     <= py;
    in_if.sample_in <= smp;
    do begin
      @(negedge clk);
      taken = in_if.ready;
      @(posedge clk);
    end while (!taken);
    // update mirror on acceptance
    if (op == OP_LOAD) begin
      if (px < StoreW && py < StoreH) pic_mirror[py*StoreW + px] = smp;
    end else if (op != OP_NONE) begin
      pending_samples.push_back(fixed ? want : resample_predict(op, px, py));
    end
  endtask

  // valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    bit taken;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_if.ready;
      @(posedge clk);
    end while (!taken);
    case (idx)
      CFG_REF_WIDTH, CFG_REF_HEIGHT:         reg_mirror[idx] = val & 64'h1FF;
      CFG_REF_BIT_DEPTH, CFG_OUT_BIT_DEPTH:  reg_mirror[idx] = val & 64'hF;
      default:                               reg_mirror[idx] = val;
    endcase
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic random_burst(input int count);
    int r;
    logic [12:0] px, py;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        px = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(FillSide - 1));
        py = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(FillSide - 1));
        send_item(OP_LOAD, px, py, 12'($urandom), 1'b0, 12'd0);
      end else begin
        px = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(300));
        py = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(300));
        send_item(r < 72 ? OP_LUMA : (r < 97 ? OP_CHROMA : OP_NONE), px, py,
                  12'($urandom), 1'b0, 12'd0);
      end
    end
  endtask

  // requests whose whole window lies in the loaded corner at 1:1 mapping
  task automatic window_burst(input int count);
    logic [12:0] px, py;
    for (int i = 0; i < count; i++) begin
      px = 13'(3 + $urandom_range(FillSide - 8));
      py = 13'(3 + $urandom_range(FillSide - 8));
      send_item(($urandom_range(1) == 0) ? OP_LUMA : OP_CHROMA, px, py,
                12'($urandom), 1'b0, 12'd0);
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_samples.size() == 0) begin
        $error("out_sample: unexpected item, actual %0d", out_if.out_sample);
        fail_count++;
      end else if (out_if.out_sample !== pending_samples[0]) begin
        $error("out_sample: expected %0d, actual %0d", pending_samples[0], out_if.out_sample);
        fail_count++;
        void'(pending_samples.pop_front());
      end else begin
        void'(pending_samples.pop_front());
      end
    end
  end

  // timeout
  initial begin
    #40ms;
    $display("tb_scalable_video_upsampler: FAIL");
    $finish;
  end

  // main sequence
  initial begin
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.op       <= OP_LOAD;
    in_if.pos_x    <= '0;
    in_if.pos_y    <= '0;
    in_if.sample_in <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= CFG_REF_WIDTH;
    cfg_if.data    <= '0;
    reg_mirror = '{64'd256, 64'd256, 64'd8, 64'd8, 64'd0, 64'd0, 64'h0001_0000_0001_0000, 64'd0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // picture limited to the loaded corner
    write_reg(CFG_REF_WIDTH, 64'(FillSide));
    write_reg(CFG_REF_HEIGHT, 64'(FillSide));
    cfg_if.valid <= 1'b0;

    // fill the corner so no request touches an unloaded entry
    for (int y = 0; y < FillSide; y++)
      for (int x = 0; x < FillSide; x++)
        send_item(OP_LOAD, 13'(x), 13'(y), FillLevel, 1'b0, 12'd0);

    // directed rows
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].smp, directed_rows[i].fixed, directed_rows[i].want);
    random_burst(300);
    drain();

    // 2x upsampling, deep bit depths, degenerate width and zero height
    write_reg(CFG_REF_WIDTH, 64'd1);
    write_reg(CFG_REF_HEIGHT, 64'd0);
    write_reg(CFG_REF_BIT_DEPTH, 64'd12);
    write_reg(CFG_OUT_BIT_DEPTH, 64'd12);
    write_reg(CFG_POS_SCALE, 64'h0000_8000_0000_8000);
    write_reg(CFG_POS_OFFSET, {32'($urandom_range(8)), 32'($urandom_range(8))});
    write_reg(CFG_POS_DELTA, {32'($urandom_range(15)), 32'($urandom_range(15))});
    write_reg(CFG_POS_ROUND_ADD, {32'($urandom_range(4095)), 32'($urandom_range(4095))});
    cfg_if.valid <= 1'b0;
    send_idle_pct = 86;
    random_burst(250);
    drain();

    // out-of-range depths, 1.5x with negative offsets
    write_reg(CFG_REF_WIDTH, 64'd12);
    write_reg(CFG_REF_HEIGHT, 64'(FillSide));
    write_reg(CFG_REF_BIT_DEPTH, 64'd7);
    write_reg(CFG_OUT_BIT_DEPTH, 64'd15);
    write_reg(CFG_POS_SCALE, 64'h0000_AAAB_0000_AAAB);
    write_reg(CFG_POS_OFFSET, 64'hFFFF_FFF0_FFFF_FFFB);
    write_reg(CFG_POS_DELTA, 64'hFFFF_FFF9_0000_0007);
    write_reg(CFG_POS_ROUND_ADD, 64'hFFFF_F800_0000_07FF);
    cfg_if.valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    random_burst(250);
    drain();

    // random geometry with full-range mapping terms
    write_reg(CFG_REF_WIDTH, 64'($urandom_range(1, FillSide)));
    write_reg(CFG_REF_HEIGHT, 64'($urandom_range(1, FillSide)));
    write_reg(CFG_REF_BIT_DEPTH, 64'($urandom_range(8, 12)));
    write_reg(CFG_OUT_BIT_DEPTH, 64'($urandom_range(8, 12)));
    write_reg(CFG_POS_SCALE, {$urandom, $urandom});
    write_reg(CFG_POS_OFFSET, {$urandom, $urandom});
    write_reg(CFG_POS_DELTA, {$urandom, $urandom});
    write_reg(CFG_POS_ROUND_ADD, {$urandom, $urandom});
    cfg_if.valid <= 1'b0;
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    random_burst(200);
    drain();

    // 8-bit to 12-bit with the scale at its extremes, zero for x and all ones for y
    write_reg(CFG_REF_WIDTH, 64'd256);
    write_reg(CFG_REF_HEIGHT, 64'd1);
    write_reg(CFG_REF_BIT_DEPTH, 64'd8);
    write_reg(CFG_OUT_BIT_DEPTH, 64'd12);
    write_reg(CFG_POS_SCALE, 64'hFFFF_FFFF_0000_0000);
    write_reg(CFG_POS_OFFSET, 64'd0);
    write_reg(CFG_POS_DELTA, 64'd0);
    write_reg(CFG_POS_ROUND_ADD, 64'd0);
    cfg_if.valid <= 1'b0;
    random_burst(100);
    drain();

    // sizes above the store, reset mapping, under mixed pressure
    write_reg(CFG_REF_WIDTH, 64'd300);
    write_reg(CFG_REF_HEIGHT, 64'd400);
    write_reg(CFG_OUT_BIT_DEPTH, 64'd8);
    write_reg(CFG_POS_SCALE, 64'h0001_0000_0001_0000);
    cfg_if.valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    window_burst(100);
    send_idle_pct = 86;
    window_burst(100);
    drain();

    if (fail_count == 0) begin
      $display("tb_scalable_video_upsampler: PASS");
    end else begin
      $display("tb_scalable_video_upsampler: FAIL");
    end
    $finish;
  end

endmodule
